// ----- src/sha256_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values, round functions and shared types.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds     = 64;
    localparam int unsigned QueueDepth = 2;

    typedef logic [31:0] t_word;

    // Byte item passed from the front part to the back part
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } t_state;

    localparam t_word Iv [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word sig0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word sig1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word bsig0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word bsig1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// ----- src/sha256_if.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream interfaces
// Valid/ready channels for input bytes and digest words.
// ----------------------------------------------------------------------------
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
    modport source (output valid, data_byte, byte_valid, last, input ready);
    modport sink   (input valid, data_byte, byte_valid, last, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- src/sha256_front.sv -----
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts words, drops empty non-last items and queues the rest.
// ----------------------------------------------------------------------------
module sha256_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sha256_in_if.sink           s_in,
    output logic                o_item_valid,
    output sha256_pkg::t_item   o_item,
    input  logic                i_item_take
);
    import sha256_pkg::*;

    localparam int unsigned PtrW = $clog2(QueueDepth);

    t_item            r_mem [QueueDepth];
    logic [PtrW-1:0]  r_wr, r_rd;
    logic [PtrW:0]    r_cnt;
    logic             w_push, w_pop, w_keep;

    assign s_in.ready   = (r_cnt != (PtrW+1)'(QueueDepth));
    assign w_keep       = s_in.byte_valid | s_in.last;
    assign w_push       = s_in.valid & s_in.ready & w_keep;
    assign w_pop        = i_item_take & o_item_valid;
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_mem[r_rd];

    // Store kept words
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= '{s_in.data_byte, s_in.byte_valid, s_in.last};
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PtrW+1)'(w_push) - (PtrW+1)'(w_pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PtrW+1)'(QueueDepth))
        else $error("queue overflow");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !w_pop)
        else $error("pop from empty queue");
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (PtrW+1)'(QueueDepth)) |-> !w_push)
        else $error("push into full queue");
endmodule

// ----- src/sha256_back.sv -----
// ----------------------------------------------------------------------------
// SHA-256 back end
// Buffers bytes, runs one compression round per cycle, pads and emits.
// ----------------------------------------------------------------------------
module sha256_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    input  sha256_pkg::t_item   i_item,
    output logic                o_item_take,
    sha256_out_if.source        m_out
);
    import sha256_pkg::*;

    t_state       r_state, n_state;
    logic [31:0]  r_buf [16];        // block buffer as 16 words
    logic [5:0]   r_cnt;             // bytes in block
    logic [63:0]  r_bits;
    t_word        r_h [8];
    t_word        r_v [8];
    logic [5:0]   r_rnd;
    logic         r_final;           // compression belongs to finish
    logic         r_second;          // length block still to go
    logic         r_pad_due;         // full block ended the message, pad next
    logic [2:0]   r_idx;

    t_word        w_t1, w_t2, w_w;
    logic         w_start_full, w_start_last;
    logic [63:0]  w_len;

    assign w_w  = r_buf[0];
    assign w_t1 = r_v[7] + bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                + RoundK[r_rnd] + w_w;
    assign w_t2 = bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign w_len = r_bits + {55'd0, r_cnt, 3'd0};

    // Take an item only when idle
    assign o_item_take  = (r_state == ST_IDLE);
    assign w_start_full = i_item_valid && i_item.byte_valid && (r_cnt == 6'd63);
    assign w_start_last = i_item_valid && i_item.last;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_start_full) n_state = ST_ROUND;
                      else if (w_start_last) n_state = ST_PAD;
            ST_PAD:   n_state = ST_ROUND;
            ST_ROUND: if (r_rnd == 6'd63) n_state = ST_FOLD;
            ST_FOLD:  if (r_second || r_pad_due) n_state = ST_PAD;
                      else if (r_final) n_state = ST_EMIT;
                      else n_state = ST_IDLE;
            ST_EMIT:  if (m_out.ready && r_idx == 3'd7) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        m_out.valid       = (r_state == ST_EMIT);
        m_out.digest_word = r_h[r_idx];
        m_out.word_index  = r_idx;
        m_out.last_word   = (r_idx == 3'd7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_bits    <= '0;
            r_final   <= 1'b0;
            r_second  <= 1'b0;
            r_pad_due <= 1'b0;
            r_idx     <= '0;
            r_rnd     <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= Iv[i];
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_rnd <= '0;
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    if (i_item_valid && i_item.byte_valid) begin
                        r_buf[r_cnt[5:2]][8*(3-r_cnt[1:0]) +: 8] <= i_item.data_byte;
                        r_cnt <= r_cnt + 6'd1;
                        if (r_cnt == 6'd63) r_bits <= r_bits + 64'd512;
                    end
                    r_final   <= w_start_last;
                    r_pad_due <= w_start_full && w_start_last;
                end
                ST_PAD: begin
                    // Pad: 0x80 at count (unless length-only block), zeros, length
                    if (r_second) begin
                        for (int j = 0; j < 14; j++) r_buf[j] <= '0;
                        r_buf[14] <= r_bits[63:32];
                        r_buf[15] <= r_bits[31:0];
                        r_second  <= 1'b0;
                    end else begin
                        for (int j = 0; j < 16; j++) begin
                            for (int b = 0; b < 4; b++) begin
                                if (6'(4*j+b) == r_cnt)
                                    r_buf[j][8*(3-b) +: 8] <= 8'h80;
                                else if (6'(4*j+b) > r_cnt)
                                    r_buf[j][8*(3-b) +: 8] <= 8'h00;
                            end
                        end
                        r_bits <= w_len;
                        if (r_cnt >= 6'd56) begin
                            r_second <= 1'b1;
                        end else begin
                            r_buf[14] <= w_len[63:32];
                            r_buf[15] <= w_len[31:0];
                        end
                        r_cnt <= '0;
                    end
                    r_pad_due <= 1'b0;
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    r_rnd <= '0;
                end
                ST_ROUND: begin
                    // Round with rolling message schedule
                    for (int j = 0; j < 15; j++) r_buf[j] <= r_buf[j+1];
                    r_buf[15] <= sig1(r_buf[14]) + r_buf[9] + sig0(r_buf[1]) + r_buf[0];
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= w_t1 + w_t2;
                    r_rnd  <= r_rnd + 6'd1;
                end
                ST_FOLD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_idx <= '0;
                end
                ST_EMIT: begin
                    if (m_out.ready) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= Iv[i];
                            r_bits  <= '0;
                            r_final <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_item_take |-> (r_state == ST_IDLE))
        else $error("item taken while busy");
    a_emit_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> r_final)
        else $error("digest emitted without finish");
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_rnd == 6'd63) |=> (r_state == ST_FOLD))
        else $error("round count slip");
endmodule

// ----- src/sha256_byte_stream_hasher_core.sv -----
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher core
// Hashes a byte stream and emits the eight-word digest on the last item.
// ----------------------------------------------------------------------------
// Usage:
//   s_in carries one message byte per word (byte_valid) and the last flag.
//   An empty word without last is dropped; an empty word with last finishes
//   the message with the bytes already taken.
//   m_out gives the digest as eight words, index 0 first, last_word on 7.
// Timing:
//   Bytes are taken while the core is idle; every 64th byte starts a
//   compression of 64 rounds plus a fold step, one round per cycle in the
//   shared round unit, and the next byte is taken only after the fold.
//   A last word adds a pad step and one or two compressions, then eight
//   output transfers, one per taken digest word.
//   A two-entry queue lets the source run ahead while the core is busy.
// Reset: synchronous, returns the chaining words to the initial vector and
//   empties the queue and the byte count. A stalled receiver holds the
//   current digest word until it is taken; input stalls once the queue fills.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sha256_in_if.sink     s_in,
    sha256_out_if.source  m_out
);
    import sha256_pkg::*;

    logic  w_item_valid;
    t_item w_item;
    logic  w_item_take;

    sha256_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_in         (s_in),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_item_take  (w_item_take)
    );

    sha256_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_take  (w_item_take),
        .m_out        (m_out)
    );
endmodule

// ----- tb/sv/tb_sha256_byte_stream_hasher_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher core testbench
// Feeds byte words with random gaps, predicts each digest with its own
// SHA-256 model and checks every digest word in order against it.
// ----------------------------------------------------------------------------
module tb_sha256_byte_stream_hasher_core;
    import sha256_pkg::*;

    logic i_clk;
    logic i_rst_n;

    sha256_in_if  s_in ();
    sha256_out_if m_out ();

    sha256_byte_stream_hasher_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (s_in),
        .m_out   (m_out)
    );

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest_entry;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 200;

    // Predictor state
    logic [31:0] hash_state [8];
    logic [7:0]  msg_block [64];
    int unsigned block_fill;
    logic [63:0] msg_length_bits;

    t_digest_entry digest_queue [$];
    int unsigned   mismatch_count;
    int unsigned   words_checked;
    int unsigned   digests_sent;
    int unsigned   bytes_sent;
    int unsigned   cycle_count;
    int unsigned   sink_hold_cycles;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Run one compression over the current block
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int r = 0; r < 16; r++) begin
            w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
        end
        for (int r = 16; r < 64; r++) begin
            w[r] = (ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
                 + (ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
        end
        for (int r = 0; r < 8; r++) v[r] = hash_state[r];
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + w[r];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int r = 0; r < 8; r++) hash_state[r] += v[r];
    endtask

    task automatic restart_hash();
        for (int r = 0; r < 8; r++) hash_state[r] = SHA_IV[r];
        block_fill = 0;
        msg_length_bits = '0;
    endtask

    // Advance the predictor by one accepted word; queue the digest on last
    task automatic predict_digest(input logic [7:0] b, input logic bv, input logic lst);
        if (bv) begin
            msg_block[block_fill] = b;
            block_fill++;
            if (block_fill == 64) begin
                compress_block();
                msg_length_bits += 64'd512;
                block_fill = 0;
            end
        end
        if (lst) begin
            msg_block[block_fill] = 8'h80;
            for (int i = block_fill + 1; i < 64; i++) msg_block[i] = 8'h00;
            if (block_fill >= 56) begin
                compress_block();
                for (int i = 0; i < 56; i++) msg_block[i] = 8'h00;
            end
            msg_length_bits += 64'(block_fill) * 8;
            for (int i = 0; i < 8; i++) msg_block[63-i] = msg_length_bits[8*i +: 8];
            compress_block();
            for (int i = 0; i < 8; i++) begin
                digest_queue.push_back('{hash_state[i], 3'(i), i == 7});
            end
            restart_hash();
        end
    endtask

    // Clock and cycle limit
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Check each accepted digest word against the oldest expectation
    always @(posedge i_clk) begin
        t_digest_entry want;
        if (i_rst_n && m_out.valid && m_out.ready) begin
            if (digest_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected digest word %h idx %0d",
                             m_out.digest_word, m_out.word_index);
            end else begin
                want = digest_queue.pop_front();
                words_checked++;
                if (want.digest_word !== m_out.digest_word
                        || want.word_index !== m_out.word_index
                        || want.last_word !== m_out.last_word) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                 want.digest_word, want.word_index, want.last_word,
                                 m_out.digest_word, m_out.word_index, m_out.last_word);
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        int unsigned gap;
        m_out.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (sink_hold_cycles > 0) begin
                sink_hold_cycles--;
                m_out.ready <= 1'b0;
            end else if (m_out.ready && !m_out.valid) begin
                m_out.ready <= 1'b1;
            end else begin
                gap = $urandom_range(0, 4);
                if (m_out.ready && m_out.valid) begin
                    // word just taken: draw a fresh stall
                    if (gap > 0 && $urandom_range(0, 3) != 0) begin
                        m_out.ready <= 1'b0;
                        sink_hold_cycles = gap - 1;
                    end
                end else begin
                    m_out.ready <= 1'b1;
                end
            end
        end
    end

    // Send one word, with a random gap before it; valid stays up after
    // acceptance so that a word with no gap follows back to back
    task automatic send_word(input logic [7:0] b, input logic bv, input logic lst,
                             input bit no_gap = 0);
        int unsigned gap;
        gap = no_gap ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            s_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        s_in.valid      <= 1'b1;
        s_in.data_byte  <= b;
        s_in.byte_valid <= bv;
        s_in.last       <= lst;
        @(posedge i_clk);
        while (!s_in.ready) @(posedge i_clk);
        predict_digest(b, bv, lst);
        if (bv) bytes_sent++;
        if (lst) digests_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_message(input int unsigned n_bytes, input bit empty_tail);
        for (int i = 0; i < n_bytes; i++) begin
            if (!empty_tail && i == n_bytes - 1)
                send_word(8'($urandom), 1'b1, 1'b1);
            else
                send_word(8'($urandom), 1'b1, 1'b0);
        end
        if (empty_tail || n_bytes == 0) send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    // Drop valid and wait until every expected digest word has come
    task automatic wait_drained();
        s_in.valid <= 1'b0;
        @(negedge i_clk);
        while (digest_queue.size() != 0) @(negedge i_clk);
    endtask

    // Directed: empty message, field extremes, idle words, short messages
    task automatic test_directed();
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'hff, 1'b1, 1'b1);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'h55, 1'b0, 1'b0);
        send_word(8'haa, 1'b1, 1'b0);
        send_word(8'h3c, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        wait_drained();
    endtask

    // Lengths around the pad and block boundaries
    task automatic test_boundaries();
        int unsigned lens [6] = '{55, 56, 63, 64, 65, 120};
        foreach (lens[i]) send_message(lens[i], i % 2);
        wait_drained();
    endtask

    // Receiver blocked while the sender keeps pushing
    task automatic test_backpressure();
        sink_hold_cycles = 600;
        for (int i = 0; i < 4; i++) send_message($urandom_range(0, 4), $urandom_range(0, 1));
        wait_drained();
    endtask

    // Random messages, mostly short, with stray empty words mixed in
    task automatic test_random();
        int unsigned n;
        while (bytes_sent < 430) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0) send_word(8'($urandom), 1'b0, 1'b0);
            send_message(n, $urandom_range(0, 1));
        end
        wait_drained();
    endtask

    initial begin
        s_in.valid      = 1'b0;
        s_in.data_byte  = '0;
        s_in.byte_valid = 1'b0;
        s_in.last       = 1'b0;
        mismatch_count  = 0;
        words_checked   = 0;
        digests_sent    = 0;
        bytes_sent      = 0;
        cycle_count     = 0;
        sink_hold_cycles = 0;
        for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
        restart_hash();
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_boundaries();
        test_backpressure();
        test_random();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d bytes in %0d messages, %0d digest words checked",
                 bytes_sent, digests_sent, words_checked);
        if (mismatch_count == 0 && digest_queue.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d words missing", mismatch_count, digest_queue.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ----- files.f -----
src/sha256_pkg.sv
src/sha256_if.sv
src/sha256_front.sv
src/sha256_back.sv
src/sha256_byte_stream_hasher_core.sv
tb/sv/tb_sha256_byte_stream_hasher_core.sv
